[design/apose_pkg.sv]
package apose_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int DIV_STAGES    = 64;
  // edges from the accepting edge to the edge that loads the result register
  localparam int PIPE_DEPTH    = CORDIC_STAGES + 74;

  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic [29:0]        INV_TWO_PI   = 30'd683565276;
  localparam logic [2:0]         REG_STRAIGHT = 3'd0;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] lin_vel;
    logic signed [31:0] ang_vel;
    logic [15:0]        time_step;
  } in_t;

  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_heading;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] lin_vel;
    logic [31:0]        heading;
    logic [31:0]        heading_n;
    logic [31:0]        dv;
    logic               neg_w;
    logic [15:0]        time_step;
    logic               arc;
    logic               flip_a;
    logic               flip_b;
    logic               neg_ax;
    logic               neg_ay;
    logic               neg_sx;
    logic               neg_sy;
    logic signed [35:0] dx_st;
    logic signed [35:0] dy_st;
  } sb_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[design/arc_pose_integrator.sv]
// arc pose integrator: exact arc odometry update of a unicycle pose
// input: pulse start with in_data valid; an item is taken at every edge where
//   start is high and busy is low. busy stays low, so an item may enter every cycle
// output: out_valid is high for one cycle with out_data; the receiver cannot
//   stall, and results leave in the order the items came in
// pipeline: the input register loads at the accepting edge, then 3 heading
//   stages, one rotation stage per cordic iteration, 5 product stages, 64 quotient
//   stages of the radius divider and 2 stages for rounding and saturation
// throughput: one item per cycle, set by the fully unrolled cordic and divider
// configuration: apb-style port, straight_threshold at byte address 0; pready
//   is always high, writes belong in idle periods
// reset: rst_n (synchronous) clears all valid bits and the threshold to zero;
//   the whole pipeline is flushed and transactions in flight are dropped
module arc_pose_integrator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  apose_pkg::in_t      in_data,
  output logic                out_valid,
  output apose_pkg::out_t     out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import apose_pkg::*;

  logic [30:0] thr_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STRAIGHT[2]) ? {1'b0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_STRAIGHT[2])) begin
      thr_r <= pwdata[30:0];
    end
  end

  // input register
  logic v0_r;
  in_t  in0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start;
  end

  always_ff @(posedge clk) begin
    if (start) in0_r <= in_data;
  end

  // stage 1: |w| * dt and path choice
  logic        v1_r;
  sb_t         sb1_r;
  logic [47:0] m1_r;
  logic [31:0] dv0;
  sb_t         sb1n;

  assign dv0 = in0_r.ang_vel[31] ? 32'(-in0_r.ang_vel) : 32'(in0_r.ang_vel);

  always_comb begin
    sb1n           = '0;
    sb1n.pos_x     = in0_r.pos_x;
    sb1n.pos_y     = in0_r.pos_y;
    sb1n.lin_vel   = in0_r.lin_vel;
    sb1n.heading   = in0_r.heading;
    sb1n.dv        = dv0;
    sb1n.neg_w     = in0_r.ang_vel[31];
    sb1n.time_step = in0_r.time_step;
    sb1n.arc       = dv0 > {1'b0, thr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    sb1_r <= sb1n;
    m1_r  <= 48'(dv0) * 48'(in0_r.time_step);
  end

  // stage 2: split product by 1/(2 pi)
  logic        v2_r;
  sb_t         sb2_r;
  logic [53:0] ph2_r;
  logic [53:0] pl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    sb2_r <= sb1_r;
    ph2_r <= 54'(m1_r[47:24]) * 54'(INV_TWO_PI);
    pl2_r <= 54'(m1_r[23:0]) * 54'(INV_TWO_PI);
  end

  // stage 3: rounded heading step, new heading, quadrant fold into the cordic
  logic signed [33:0] ax_r [0:CORDIC_STAGES];
  logic signed [33:0] ay_r [0:CORDIC_STAGES];
  logic signed [33:0] az_r [0:CORDIC_STAGES];
  logic signed [33:0] bx_r [0:CORDIC_STAGES];
  logic signed [33:0] by_r [0:CORDIC_STAGES];
  logic signed [33:0] bz_r [0:CORDIC_STAGES];
  sb_t                sbc_r [0:CORDIC_STAGES];
  logic [CORDIC_STAGES:0] vc_r;

  logic [55:0] frac3;
  logic [37:0] r3;
  logic [31:0] delta3;
  logic [31:0] hn3;
  logic        flip_a3;
  logic        flip_b3;
  sb_t         sb3;

  always_comb begin
    frac3   = 56'({ph2_r[15:0], 24'd0}) + 56'(pl2_r) + 56'h80_0000_0000;
    r3      = ph2_r[53:16] + 38'(frac3[55:40]);
    delta3  = r3[31:0];
    hn3     = sb2_r.heading;
    if (sb2_r.arc) hn3 = sb2_r.heading + (sb2_r.neg_w ? (32'd0 - delta3) : delta3);
    flip_a3 = sb2_r.heading[31] ^ sb2_r.heading[30];
    flip_b3 = hn3[31] ^ hn3[30];
    sb3           = sb2_r;
    sb3.heading_n = hn3;
    sb3.flip_a    = flip_a3;
    sb3.flip_b    = flip_b3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r[0] <= 1'b0;
    else vc_r[0] <= v2_r;
  end

  always_ff @(posedge clk) begin
    sbc_r[0] <= sb3;
    ax_r[0]  <= CORDIC_GAIN;
    ay_r[0]  <= '0;
    az_r[0]  <= 34'(signed'({sb2_r.heading[31] ^ flip_a3, sb2_r.heading[30:0]}));
    bx_r[0]  <= CORDIC_GAIN;
    by_r[0]  <= '0;
    bz_r[0]  <= 34'(signed'({hn3[31] ^ flip_b3, hn3[30:0]}));
  end

  // rotation stages, two lanes: old heading (a) and new heading (b)
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [33:0] xsa, ysa, xsb, ysb, atn;

    assign xsa = ax_r[i] >>> i;
    assign ysa = ay_r[i] >>> i;
    assign xsb = bx_r[i] >>> i;
    assign ysb = by_r[i] >>> i;
    assign atn = signed'(34'(atan_bam(5'(i))));

    always_ff @(posedge clk) begin
      if (!rst_n) vc_r[i+1] <= 1'b0;
      else vc_r[i+1] <= vc_r[i];
    end

    always_ff @(posedge clk) begin
      sbc_r[i+1] <= sbc_r[i];
      if (!az_r[i][33]) begin
        ax_r[i+1] <= ax_r[i] - ysa;
        ay_r[i+1] <= ay_r[i] + xsa;
        az_r[i+1] <= az_r[i] - atn;
      end else begin
        ax_r[i+1] <= ax_r[i] + ysa;
        ay_r[i+1] <= ay_r[i] - xsa;
        az_r[i+1] <= az_r[i] + atn;
      end
      if (!bz_r[i][33]) begin
        bx_r[i+1] <= bx_r[i] - ysb;
        by_r[i+1] <= by_r[i] + xsb;
        bz_r[i+1] <= bz_r[i] - atn;
      end else begin
        bx_r[i+1] <= bx_r[i] + ysb;
        by_r[i+1] <= by_r[i] - xsb;
        bz_r[i+1] <= bz_r[i] + atn;
      end
    end
  end

  // p1: unfold and differences
  logic               vp1_r;
  sb_t                sbp1_r;
  logic signed [33:0] dsin_r, dcos_r, s0_r, c0_r;
  logic signed [33:0] s0c, c0c, s1c, c1c;
  sb_t                sbce;

  always_comb begin
    sbce = sbc_r[CORDIC_STAGES];
    s0c  = sbce.flip_a ? -ay_r[CORDIC_STAGES] : ay_r[CORDIC_STAGES];
    c0c  = sbce.flip_a ? -ax_r[CORDIC_STAGES] : ax_r[CORDIC_STAGES];
    s1c  = sbce.flip_b ? -by_r[CORDIC_STAGES] : by_r[CORDIC_STAGES];
    c1c  = sbce.flip_b ? -bx_r[CORDIC_STAGES] : bx_r[CORDIC_STAGES];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vp1_r <= 1'b0;
    else vp1_r <= vc_r[CORDIC_STAGES];
  end

  always_ff @(posedge clk) begin
    sbp1_r <= sbce;
    dsin_r <= s1c - s0c;
    dcos_r <= c0c - c1c;
    s0_r   <= s0c;
    c0_r   <= c0c;
  end

  // p2: magnitude products
  logic        vp2_r;
  sb_t         sbp2_r;
  logic [65:0] nx2_r, ny2_r, ax2_r, ay2_r;
  logic [31:0] vmag1;
  sb_t         sbp2n;

  function automatic logic [33:0] mag34(input logic signed [33:0] a);
    return a[33] ? 34'(-a) : 34'(a);
  endfunction

  always_comb begin
    vmag1 = sbp1_r.lin_vel[31] ? 32'(-sbp1_r.lin_vel) : 32'(sbp1_r.lin_vel);
    sbp2n        = sbp1_r;
    sbp2n.neg_ax = sbp1_r.lin_vel[31] ^ dsin_r[33] ^ sbp1_r.neg_w;
    sbp2n.neg_ay = sbp1_r.lin_vel[31] ^ dcos_r[33] ^ sbp1_r.neg_w;
    sbp2n.neg_sx = sbp1_r.lin_vel[31] ^ c0_r[33];
    sbp2n.neg_sy = sbp1_r.lin_vel[31] ^ s0_r[33];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vp2_r <= 1'b0;
    else vp2_r <= vp1_r;
  end

  always_ff @(posedge clk) begin
    sbp2_r <= sbp2n;
    nx2_r  <= 66'(vmag1) * 66'(mag34(dsin_r));
    ny2_r  <= 66'(vmag1) * 66'(mag34(dcos_r));
    ax2_r  <= 66'(vmag1) * 66'(mag34(c0_r));
    ay2_r  <= 66'(vmag1) * 66'(mag34(s0_r));
  end

  // p3: rounding offset for the quotient, straight path first rounding
  logic        vp3_r;
  sb_t         sbp3_r;
  logic [63:0] numx3_r, numy3_r;
  logic [34:0] m1x3_r, m1y3_r;
  logic [65:0] rax, ray;

  assign rax = (ax2_r + 66'h2000_0000) >> 30;
  assign ray = (ay2_r + 66'h2000_0000) >> 30;

  always_ff @(posedge clk) begin
    if (!rst_n) vp3_r <= 1'b0;
    else vp3_r <= vp2_r;
  end

  always_ff @(posedge clk) begin
    sbp3_r  <= sbp2_r;
    numx3_r <= nx2_r[63:0] + 64'(sbp2_r.dv >> 1);
    numy3_r <= ny2_r[63:0] + 64'(sbp2_r.dv >> 1);
    m1x3_r  <= rax[34:0];
    m1y3_r  <= ray[34:0];
  end

  // p4: straight path times dt
  logic        vp4_r;
  sb_t         sbp4_r;
  logic [63:0] numx4_r, numy4_r;
  logic [50:0] px4_r, py4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vp4_r <= 1'b0;
    else vp4_r <= vp3_r;
  end

  always_ff @(posedge clk) begin
    sbp4_r  <= sbp3_r;
    numx4_r <= numx3_r;
    numy4_r <= numy3_r;
    px4_r   <= 51'(m1x3_r) * 51'(sbp3_r.time_step);
    py4_r   <= 51'(m1y3_r) * 51'(sbp3_r.time_step);
  end

  // p5: straight path result, divider load
  logic [DIV_STAGES:0] vd_r;
  sb_t                 sbd_r [0:DIV_STAGES];
  logic [31:0]         rx_r  [0:DIV_STAGES];
  logic [31:0]         ry_r  [0:DIV_STAGES];
  logic [63:0]         qx_r  [0:DIV_STAGES];
  logic [63:0]         qy_r  [0:DIV_STAGES];
  logic [50:0]         rpx, rpy;
  sb_t                 sbp5n;

  always_comb begin
    rpx   = (px4_r + 51'h8000) >> 16;
    rpy   = (py4_r + 51'h8000) >> 16;
    sbp5n = sbp4_r;
    sbp5n.dx_st = sbp4_r.neg_sx ? -signed'(36'(rpx[34:0])) : signed'(36'(rpx[34:0]));
    sbp5n.dy_st = sbp4_r.neg_sy ? -signed'(36'(rpy[34:0])) : signed'(36'(rpy[34:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r[0] <= 1'b0;
    else vd_r[0] <= vp4_r;
  end

  always_ff @(posedge clk) begin
    sbd_r[0] <= sbp5n;
    rx_r[0]  <= '0;
    ry_r[0]  <= '0;
    qx_r[0]  <= numx4_r;
    qy_r[0]  <= numy4_r;
  end

  // restoring divider, one quotient bit per stage; numerator bits shift out
  // of the top of q while quotient bits shift in at the bottom
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [32:0] tx, ty, dfx, dfy;
    logic        gex, gey;

    assign tx  = {rx_r[k], qx_r[k][63]};
    assign ty  = {ry_r[k], qy_r[k][63]};
    assign dfx = tx - {1'b0, sbd_r[k].dv};
    assign dfy = ty - {1'b0, sbd_r[k].dv};
    assign gex = tx >= {1'b0, sbd_r[k].dv};
    assign gey = ty >= {1'b0, sbd_r[k].dv};

    always_ff @(posedge clk) begin
      if (!rst_n) vd_r[k+1] <= 1'b0;
      else vd_r[k+1] <= vd_r[k];
    end

    always_ff @(posedge clk) begin
      sbd_r[k+1] <= sbd_r[k];
      rx_r[k+1]  <= gex ? dfx[31:0] : tx[31:0];
      ry_r[k+1]  <= gey ? dfy[31:0] : ty[31:0];
      qx_r[k+1]  <= {qx_r[k][62:0], gex};
      qy_r[k+1]  <= {qy_r[k][62:0], gey};
    end
  end

  // f1: radius rounding to q.16 and path select
  logic               vf1_r;
  sb_t                sbf1_r;
  logic signed [59:0] dx1_r, dy1_r;
  logic [63:0]        qqx, qqy;
  logic signed [59:0] dxa, dya;
  sb_t                sbde;

  always_comb begin
    sbde = sbd_r[DIV_STAGES];
    qqx  = (qx_r[DIV_STAGES] + 64'd32) >> 6;
    qqy  = (qy_r[DIV_STAGES] + 64'd32) >> 6;
    dxa  = sbde.neg_ax ? -signed'(60'(qqx[58:0])) : signed'(60'(qqx[58:0]));
    dya  = sbde.neg_ay ? -signed'(60'(qqy[58:0])) : signed'(60'(qqy[58:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vf1_r <= 1'b0;
    else vf1_r <= vd_r[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    sbf1_r <= sbde;
    dx1_r  <= sbde.arc ? dxa : 60'(sbde.dx_st);
    dy1_r  <= sbde.arc ? dya : 60'(sbde.dy_st);
  end

  // f2: position sum and clipping into the output register
  logic signed [61:0] sumx, sumy;
  logic               satx, saty;
  logic               out_valid_r;
  out_t               out_data_r;

  function automatic logic signed [31:0] clip32(input logic signed [61:0] a);
    logic signed [31:0] res;
    if (a > 62'sd2147483647) res = 32'sh7FFF_FFFF;
    else if (a < -62'sd2147483648) res = 32'sh8000_0000;
    else res = a[31:0];
    return res;
  endfunction

  always_comb begin
    sumx = 62'(sbf1_r.pos_x) + 62'(dx1_r);
    sumy = 62'(sbf1_r.pos_y) + 62'(dy1_r);
    satx = (sumx > 62'sd2147483647) || (sumx < -62'sd2147483648);
    saty = (sumy > 62'sd2147483647) || (sumy < -62'sd2147483648);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= vf1_r;
  end

  always_ff @(posedge clk) begin
    out_data_r.next_x       <= clip32(sumx);
    out_data_r.next_y       <= clip32(sumy);
    out_data_r.next_heading <= sbf1_r.heading_n;
    out_data_r.saturated    <= satx || saty;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/apose_chk.sv]
module apose_chk (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  logic            out_valid,
  input  apose_pkg::out_t out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic [31:0]     prdata
);
  import apose_pkg::*;

  // the block never refuses an item
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every result goes back to an accepted transaction a fixed depth earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_DEPTH + 1))
    else $error("result without matching transaction");

  // threshold reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && !paddr[2]) |=>
      (paddr[2] || prdata == ($past(pwdata) & 32'h7FFF_FFFF)))
    else $error("threshold readback mismatch");

  // a clipped result sits on a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.next_x == 32'sh7FFF_FFFF || out_data.next_x == 32'sh8000_0000 ||
       out_data.next_y == 32'sh7FFF_FFFF || out_data.next_y == 32'sh8000_0000))
    else $error("saturated flag without clipped position");

endmodule

bind arc_pose_integrator apose_chk u_apose_chk (.*);
